>>> rtl/nprs_pkg.sv
// Shared types and codes for the NAND page read sequencer.
`timescale 1ns / 1ps
package nprs_pkg;

   localparam int ADDR_W         = 29;
   localparam int LEN_W          = 30;
   localparam int PAGE_BYTES_DEF = 2 * 1024;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_READY = 2'd1;
   localparam logic [1:0] OP_DATA  = 2'd2;

   localparam logic [1:0] PHASE_IDLE = 2'd0;
   localparam logic [1:0] PHASE_WAIT = 2'd1;
   localparam logic [1:0] PHASE_DATA = 2'd2;

   localparam logic [2:0] KIND_SELECT   = 3'd0;
   localparam logic [2:0] KIND_DESELECT = 3'd1;
   localparam logic [2:0] KIND_COMMAND  = 3'd2;
   localparam logic [2:0] KIND_ADDRESS  = 3'd3;
   localparam logic [2:0] KIND_DATA     = 3'd4;

   localparam logic [1:0] TAIL_NONE     = 2'd0;
   localparam logic [1:0] TAIL_DESELECT = 2'd1;
   localparam logic [1:0] TAIL_SETUP    = 2'd2;

   localparam logic [7:0] CMD_READ        = 8'h00;
   localparam logic [7:0] CMD_CONFIRM     = 8'h30;
   localparam logic [7:0] COL_HIGH_MASK   = 8'h0f;
   localparam logic [7:0] PAGE_HIGH_MASK  = 8'h03;

   typedef struct packed {
      logic [2:0]        first_kind;
      logic [7:0]        first_byte;
      logic [ADDR_W-1:0] first_index;
      logic [1:0]        tail;
      logic [ADDR_W-1:0] setup_addr;
   } desc_type;

endpackage

>>> rtl/nprs_ctrl.sv
// Phase and counter state, turning each request into a burst descriptor.
`timescale 1ns / 1ps
module nprs_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_opcode,
   input  logic [nprs_pkg::ADDR_W-1:0] req_start_address,
   input  logic [nprs_pkg::LEN_W-1:0] req_read_length,
   input  logic                       req_ready_bit,
   input  logic [7:0]                 req_flash_byte,
   input  logic                       emit_free,
   output logic                       pend_valid,
   output nprs_pkg::desc_type         pend_desc,
   input  logic [31:0]                page_bytes
);
   import nprs_pkg::*;

   logic [1:0]        phase_ff, phase_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic [ADDR_W-1:0] index_ff, index_in;
   logic              pend_valid_ff, pend_valid_in;
   desc_type          pend_desc_ff, pend_desc_in;

   logic              accept;
   logic              emits;
   logic [ADDR_W-1:0] addr_inc;
   logic [ADDR_W-1:0] col_mask;

   assign accept    = req_valid && (!pend_valid_ff || emit_free);
   assign req_stall = pend_valid_ff && !emit_free;
   assign addr_inc  = addr_ff + ADDR_W'(1);
   assign col_mask  = ADDR_W'(page_bytes - 32'd1);

   always_comb begin
      phase_in     = phase_ff;
      addr_in      = addr_ff;
      remain_in    = remain_ff;
      index_in     = index_ff;
      emits        = 1'b0;
      pend_desc_in = pend_desc_ff;
      if (accept) begin
         if (req_opcode == OP_START && phase_ff == PHASE_IDLE) begin
            emits                    = 1'b1;
            addr_in                  = req_start_address;
            remain_in                = req_read_length;
            index_in                 = '0;
            pend_desc_in.first_kind  = KIND_SELECT;
            pend_desc_in.first_byte  = '0;
            pend_desc_in.first_index = '0;
            pend_desc_in.setup_addr  = req_start_address;
            if (req_read_length == '0) begin
               pend_desc_in.tail = TAIL_DESELECT;
            end else begin
               pend_desc_in.tail = TAIL_SETUP;
               phase_in          = PHASE_WAIT;
            end
         end else if (req_opcode == OP_READY && phase_ff == PHASE_WAIT) begin
            if (req_ready_bit) begin
               phase_in = PHASE_DATA;
            end
         end else if (req_opcode == OP_DATA && phase_ff == PHASE_DATA) begin
            emits                    = 1'b1;
            addr_in                  = addr_inc;
            remain_in                = remain_ff - LEN_W'(1);
            index_in                 = index_ff + ADDR_W'(1);
            pend_desc_in.first_kind  = KIND_DATA;
            pend_desc_in.first_byte  = req_flash_byte;
            pend_desc_in.first_index = index_ff;
            pend_desc_in.setup_addr  = addr_inc;
            if (remain_ff == LEN_W'(1)) begin
               pend_desc_in.tail = TAIL_DESELECT;
               phase_in          = PHASE_IDLE;
            end else if ((addr_inc & col_mask) == '0) begin
               pend_desc_in.tail = TAIL_SETUP;
               phase_in          = PHASE_WAIT;
            end else begin
               pend_desc_in.tail = TAIL_NONE;
            end
         end
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (emits) begin
         pend_valid_in = 1'b1;
      end else if (emit_free) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_IDLE;
         addr_ff       <= '0;
         remain_ff     <= '0;
         index_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         addr_ff       <= addr_in;
         remain_ff     <= remain_in;
         index_ff      <= index_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_desc_ff <= pend_desc_in;
   end

   assign pend_valid = pend_valid_ff;
   assign pend_desc  = pend_desc_ff;

endmodule

>>> rtl/nprs_emit.sv
// Result register stepping through the cycles of one burst descriptor.
`timescale 1ns / 1ps
module nprs_emit #(
   parameter int PAGE_BYTES = nprs_pkg::PAGE_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pend_valid,
   input  nprs_pkg::desc_type          pend_desc,
   output logic                        emit_free,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_cycle_kind,
   output logic [7:0]                  rsp_byte_value,
   output logic [nprs_pkg::ADDR_W-1:0] rsp_buffer_index,
   output logic                        rsp_last_of_run
);
   import nprs_pkg::*;

   localparam int COL_W  = $clog2(PAGE_BYTES);

   localparam logic [2:0] STEP_FIRST    = 3'd0;
   localparam logic [2:0] STEP_READ     = 3'd1;
   localparam logic [2:0] STEP_COL_LOW  = 3'd2;
   localparam logic [2:0] STEP_COL_HIGH = 3'd3;
   localparam logic [2:0] STEP_PAGE_LOW = 3'd4;
   localparam logic [2:0] STEP_PAGE_MID = 3'd5;
   localparam logic [2:0] STEP_PAGE_TOP = 3'd6;
   localparam logic [2:0] STEP_CONFIRM  = 3'd7;

   logic       busy_ff, busy_in;
   logic [2:0] step_ff, step_in;
   desc_type   desc_ff, desc_in;

   logic [2:0]  last_step;
   logic        last;
   logic        taken;
   logic [15:0] col16;
   logic [23:0] page24;

   assign col16  = 16'(desc_ff.setup_addr[COL_W-1:0]);
   assign page24 = 24'(desc_ff.setup_addr[ADDR_W-1:COL_W]);

   always_comb begin
      unique case (desc_ff.tail)
         TAIL_DESELECT: last_step = STEP_READ;
         TAIL_SETUP:    last_step = STEP_CONFIRM;
         default:       last_step = STEP_FIRST;
      endcase
   end

   assign last      = step_ff == last_step;
   assign taken     = busy_ff && !rsp_stall;
   assign emit_free = !busy_ff || (taken && last);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      desc_in = desc_ff;
      if (emit_free) begin
         busy_in = pend_valid;
         step_in = STEP_FIRST;
         if (pend_valid) begin
            desc_in = pend_desc;
         end
      end else if (taken) begin
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_FIRST;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

   always_comb begin
      rsp_buffer_index = '0;
      if (step_ff == STEP_FIRST) begin
         rsp_cycle_kind   = desc_ff.first_kind;
         rsp_byte_value   = desc_ff.first_byte;
         rsp_buffer_index = desc_ff.first_index;
      end else if (desc_ff.tail == TAIL_DESELECT) begin
         rsp_cycle_kind = KIND_DESELECT;
         rsp_byte_value = '0;
      end else begin
         rsp_cycle_kind = KIND_ADDRESS;
         unique case (step_ff)
            STEP_READ: begin
               rsp_cycle_kind = KIND_COMMAND;
               rsp_byte_value = CMD_READ;
            end
            STEP_COL_LOW:  rsp_byte_value = col16[7:0];
            STEP_COL_HIGH: rsp_byte_value = col16[15:8] & COL_HIGH_MASK;
            STEP_PAGE_LOW: rsp_byte_value = page24[7:0];
            STEP_PAGE_MID: rsp_byte_value = page24[15:8];
            STEP_PAGE_TOP: rsp_byte_value = page24[23:16] & PAGE_HIGH_MASK;
            default: begin
               rsp_cycle_kind = KIND_COMMAND;
               rsp_byte_value = CMD_CONFIRM;
            end
         endcase
      end
   end

   assign rsp_valid       = busy_ff;
   assign rsp_last_of_run = last;

endmodule

>>> rtl/nand_page_read_sequencer_core.sv
// Top level of the NAND page read sequencer.
// Requests arrive on the req_ channel (valid/stall): opcode 0 starts a read
// of read_length bytes at start_address, opcode 1 carries a ready sample and
// opcode 2 a data byte from the flash. Requests out of phase are dropped.
// Results leave on the rsp_ channel one per cycle while rsp_stall is low:
// select, deselect, command, address or data cycles, with last_of_run on the
// final result of a request. A request is taken in any cycle in which the
// one-entry holding register is empty or hands its burst to the result
// register, so requests may follow back to back; a request gives no results
// or up to eight (set by the command and address burst of a page setup),
// which the result register works through in turn. The first result is
// offered after the holding register and then the result register, or
// later while the result register still works through an earlier burst.
// While rsp_stall is high the current result holds, and req_stall rises
// while the holding register is full and its burst cannot move on.
// Reset clears the phase to idle and the address, length and index counters
// to zero, and empties both the holding and result registers.
`timescale 1ns / 1ps
module nand_page_read_sequencer_core #(
   parameter int PAGE_BYTES = nprs_pkg::PAGE_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_opcode,
   input  logic [nprs_pkg::ADDR_W-1:0] req_start_address,
   input  logic [nprs_pkg::LEN_W-1:0]  req_read_length,
   input  logic                        req_ready_bit,
   input  logic [7:0]                  req_flash_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_cycle_kind,
   output logic [7:0]                  rsp_byte_value,
   output logic [nprs_pkg::ADDR_W-1:0] rsp_buffer_index,
   output logic                        rsp_last_of_run
);
   import nprs_pkg::*;

   logic     emit_free;
   logic     pend_valid;
   desc_type pend_desc;

   nprs_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_start_address (req_start_address),
      .req_read_length   (req_read_length),
      .req_ready_bit     (req_ready_bit),
      .req_flash_byte    (req_flash_byte),
      .emit_free         (emit_free),
      .pend_valid        (pend_valid),
      .pend_desc         (pend_desc),
      .page_bytes        (32'(PAGE_BYTES))
   );

   nprs_emit #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_emit (
      .clock            (clock),
      .reset            (reset),
      .pend_valid       (pend_valid),
      .pend_desc        (pend_desc),
      .emit_free        (emit_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cycle_kind   (rsp_cycle_kind),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_buffer_index (rsp_buffer_index),
      .rsp_last_of_run  (rsp_last_of_run)
   );

`ifndef SYNTHESIS
   a_select_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cycle_kind == KIND_SELECT |-> !rsp_last_of_run)
      else $error("select cycle marked as last of run");

   a_index_only_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cycle_kind != KIND_DATA |-> rsp_buffer_index == '0)
      else $error("buffer index set on a non-data cycle");

   a_select_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_cycle_kind == KIND_SELECT || rsp_cycle_kind == KIND_DESELECT)
      |-> rsp_byte_value == 8'h00)
      else $error("select or deselect carries a byte value");

   a_deselect_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cycle_kind == KIND_DESELECT |-> rsp_last_of_run)
      else $error("deselect cycle not last of run");
`endif

endmodule
